### src/bmc_pkg.sv
`timescale 1ns / 1ps

package bmc_pkg;

   localparam int CMD_BITS   = 3;
   localparam int IDENT_BITS = 22;
   localparam int LEVEL_BITS = 9;
   localparam int FUND_BITS  = 50;

   // one millisecond is 2**6 times an odd factor, divided by shift and reciprocal
   localparam int unsigned NS_PER_MS = 1000000;
   localparam int MS_SHIFT    = 6;
   localparam int MS_ODD      = int'(NS_PER_MS >> MS_SHIFT);
   localparam int MS_ODD_BITS = $clog2(MS_ODD);

   typedef logic signed [FUND_BITS-1:0] fund_type;
   typedef logic [IDENT_BITS-1:0]       ident_type;
   typedef logic [LEVEL_BITS-1:0]       level_type;

   localparam fund_type FUND_MAX    = {1'b0, {(FUND_BITS-1){1'b1}}};
   localparam fund_type FUND_MIN    = {1'b1, {(FUND_BITS-1){1'b0}}};
   localparam fund_type FUND_ONE_MS = FUND_BITS'(NS_PER_MS);

   typedef enum logic [CMD_BITS-1:0] {
      CMD_RELEASE_BEGIN = 3'd0,
      CMD_RELEASED_JOB  = 3'd1,
      CMD_RELEASE_END   = 3'd2,
      CMD_SCHEDULE      = 3'd3,
      CMD_NEW_TASK      = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_NORMAL   = 2'd0,
      MODE_BAILOUT  = 2'd1,
      MODE_RECOVERY = 2'd2
   } mode_type;

   // event fields plus the time differences worked out on entry
   typedef struct packed {
      cmd_type   cmd;
      logic      crit;
      ident_type ident;
      level_type level;
      logic      finishes;
      logic      idle;
      logic      outranks;
      logic      head_crit;
      logic      st_gt_lo;
      fund_type  d_hl;
      fund_type  d_ls;
      fund_type  d_hs;
      fund_type  d_l0;
   } item_type;

   // comparison of the two millisecond quotients
   typedef struct packed {
      logic gt;
      logic lt;
   } cmp_type;

   typedef struct packed {
      mode_type  mode;
      fund_type  fund;
      ident_type low_task;
      logic      preempt;
   } rsp_type;

endpackage

### src/bmc_if.sv
`timescale 1ns / 1ps

interface bmc_req_if import bmc_pkg::*; #(parameter int TIME_BITS = 48);
   logic                  valid;
   logic                  ready;
   logic [CMD_BITS-1:0]   command;
   logic [TIME_BITS-1:0]  exec_time;
   logic [TIME_BITS-1:0]  budget_low;
   logic [TIME_BITS-1:0]  budget_high;
   logic                  is_critical;
   logic [IDENT_BITS-1:0] task_ident;
   logic [LEVEL_BITS-1:0] task_level;
   logic                  job_finishes;
   logic                  goes_idle;
   logic                  head_outranks;
   logic                  head_critical;

   modport source (
      output valid, command, exec_time, budget_low, budget_high, is_critical,
             task_ident, task_level, job_finishes, goes_idle, head_outranks,
             head_critical,
      input  ready
   );
   modport sink (
      input  valid, command, exec_time, budget_low, budget_high, is_critical,
             task_ident, task_level, job_finishes, goes_idle, head_outranks,
             head_critical,
      output ready
   );
endinterface

interface bmc_rsp_if import bmc_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [1:0]            mode_now;
   logic [FUND_BITS-1:0]  fund_now;
   logic [IDENT_BITS-1:0] low_prio_task;
   logic                  preempt_now;

   modport source (
      output valid, mode_now, fund_now, low_prio_task, preempt_now,
      input  ready
   );
   modport sink (
      input  valid, mode_now, fund_now, low_prio_task, preempt_now,
      output ready
   );
endinterface

### src/bmc_div_stage.sv
`timescale 1ns / 1ps

module bmc_div_stage import bmc_pkg::*; #(
   parameter int TIME_BITS = 48
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  item_type             in_item,
   input  logic [TIME_BITS-1:0] in_st,
   input  logic [TIME_BITS-1:0] in_lo,
   output logic                 out_valid,
   input  logic                 out_ready,
   output item_type             out_item,
   output cmp_type              out_cmp
);

   // x / 1000000 = (x >> 6) / 15625, the second by reciprocal multiplication
   localparam int Y_BITS  = TIME_BITS - MS_SHIFT;
   localparam int S_BITS  = Y_BITS + MS_ODD_BITS;
   localparam int Q_BITS  = Y_BITS + 1 - MS_ODD_BITS;
   localparam int P_BITS  = 2 * Y_BITS + 1;
   // operand halves, so that each partial product stays near 21 by 22 bits at the default width
   localparam int YL_BITS = (Y_BITS + 1) / 2;
   localparam int YH_BITS = Y_BITS - YL_BITS;
   localparam int ML_BITS = (Y_BITS + 2) / 2;
   localparam int MH_BITS = Y_BITS + 1 - ML_BITS;

   localparam logic [S_BITS:0] POW_S      = {1'b1, {S_BITS{1'b0}}};
   localparam logic [S_BITS:0] RECIP_WIDE =
      (POW_S + (S_BITS+1)'(MS_ODD - 1)) / (S_BITS+1)'(MS_ODD);
   localparam logic [Y_BITS:0]    RECIP    = RECIP_WIDE[Y_BITS:0];
   localparam logic [ML_BITS-1:0] RECIP_LO = RECIP[ML_BITS-1:0];
   localparam logic [MH_BITS-1:0] RECIP_HI = RECIP[Y_BITS:ML_BITS];

   typedef struct packed {
      logic [YH_BITS+MH_BITS-1:0] hh;
      logic [YH_BITS+ML_BITS-1:0] hl;
      logic [YL_BITS+MH_BITS-1:0] lh;
      logic [YL_BITS+ML_BITS-1:0] ll;
   } part_type;

   function automatic part_type split_mul(input logic [TIME_BITS-1:0] x);
      logic [Y_BITS-1:0] y;
      part_type          p;
      y    = x[TIME_BITS-1:MS_SHIFT];
      p.hh = (YH_BITS+MH_BITS)'(y[Y_BITS-1:YL_BITS]) * (YH_BITS+MH_BITS)'(RECIP_HI);
      p.hl = (YH_BITS+ML_BITS)'(y[Y_BITS-1:YL_BITS]) * (YH_BITS+ML_BITS)'(RECIP_LO);
      p.lh = (YL_BITS+MH_BITS)'(y[YL_BITS-1:0]) * (YL_BITS+MH_BITS)'(RECIP_HI);
      p.ll = (YL_BITS+ML_BITS)'(y[YL_BITS-1:0]) * (YL_BITS+ML_BITS)'(RECIP_LO);
      return p;
   endfunction

   function automatic logic [Q_BITS-1:0] merge_quo(input part_type p);
      logic [P_BITS-1:0] sum;
      sum = ((P_BITS'(p.hh) << (YL_BITS + ML_BITS)) + (P_BITS'(p.hl) << YL_BITS))
          + ((P_BITS'(p.lh) << ML_BITS) + P_BITS'(p.ll));
      return sum[P_BITS-1:S_BITS];
   endfunction

   logic              a_valid_ff, b_valid_ff;
   logic              b_ready;
   item_type          a_item_ff, b_item_ff;
   part_type          a_st_ff, a_st_in;
   part_type          a_lo_ff, a_lo_in;
   cmp_type           b_cmp_ff, b_cmp_in;
   logic [Q_BITS-1:0] q_st, q_lo;

   assign b_ready  = !b_valid_ff || out_ready;
   assign in_ready = !a_valid_ff || b_ready;

   always_comb begin
      a_st_in     = split_mul(in_st);
      a_lo_in     = split_mul(in_lo);
      q_st        = merge_quo(a_st_ff);
      q_lo        = merge_quo(a_lo_ff);
      b_cmp_in.gt = q_st > q_lo;
      b_cmp_in.lt = q_st < q_lo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            a_valid_ff <= in_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         a_item_ff <= in_item;
         a_st_ff   <= a_st_in;
         a_lo_ff   <= a_lo_in;
      end
      if (a_valid_ff && b_ready) begin
         b_item_ff <= a_item_ff;
         b_cmp_ff  <= b_cmp_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_item  = b_item_ff;
   assign out_cmp   = b_cmp_ff;

`ifndef SYNTH
   a_cmp_excl: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> !(b_cmp_ff.gt && b_cmp_ff.lt))
      else $error("quotient compare both greater and less");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && !out_ready |=> b_valid_ff && $stable(b_cmp_ff))
      else $error("waiting compare word changed");
   a_mid_hold: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !b_ready |=> a_valid_ff)
      else $error("waiting product word lost");
`endif

endmodule

### src/bmc_core.sv
`timescale 1ns / 1ps

module bmc_core import bmc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   input  cmp_type  in_cmp,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   function automatic fund_type fund_sat(input logic signed [FUND_BITS:0] v);
      if (v > (FUND_BITS+1)'(FUND_MAX)) begin
         return FUND_MAX;
      end else if (v < (FUND_BITS+1)'(FUND_MIN)) begin
         return FUND_MIN;
      end
      return v[FUND_BITS-1:0];
   endfunction

   function automatic fund_type fund_sub(input fund_type a, input fund_type b);
      logic signed [FUND_BITS:0] s;
      s = (FUND_BITS+1)'(a) - (FUND_BITS+1)'(b);
      return fund_sat(s);
   endfunction

   function automatic fund_type fund_add(input fund_type a, input fund_type b);
      logic signed [FUND_BITS:0] s;
      s = (FUND_BITS+1)'(a) + (FUND_BITS+1)'(b);
      return fund_sat(s);
   endfunction

   mode_type  mode_ff, mode_in;
   fund_type  fund_ff, fund_in;
   ident_type low_task_ff, low_task_in;
   level_type low_level_ff, low_level_in;
   logic      preempt_in;
   logic      rsp_valid_ff;
   rsp_type   rsp_data_ff;
   logic      fire;
   logic      exists, hi;
   fund_type  drain;

   assign in_ready = !rsp_valid_ff || rsp_ready;
   assign fire     = in_valid && in_ready;

   always_comb begin
      mode_in      = mode_ff;
      fund_in      = fund_ff;
      low_task_in  = low_task_ff;
      low_level_in = low_level_ff;
      preempt_in   = 1'b0;
      exists       = in_item.ident != '0;
      hi           = exists && in_item.crit;
      drain        = in_item.d_ls;
      case (in_item.cmd)
         CMD_RELEASE_BEGIN: begin
            if (mode_ff != MODE_BAILOUT && in_item.st_gt_lo) begin
               mode_in = MODE_BAILOUT;
               fund_in = in_item.d_hl;
            end
         end
         CMD_RELEASED_JOB: begin
            if (mode_ff != MODE_RECOVERY) begin
               if (low_task_ff == '0 || in_item.level > low_level_ff) begin
                  low_task_in  = in_item.ident;
                  low_level_in = in_item.level;
               end
            end
            if (mode_ff != MODE_NORMAL && !in_item.crit) begin
               fund_in = fund_sub(fund_ff, in_item.d_l0);
               if (mode_ff == MODE_BAILOUT && fund_in < FUND_ONE_MS) begin
                  mode_in = MODE_RECOVERY;
                  fund_in = '0;
               end
            end
         end
         CMD_RELEASE_END: begin
            if (mode_ff == MODE_NORMAL) begin
               preempt_in = in_item.outranks;
            end else begin
               preempt_in = in_item.outranks && in_item.head_crit;
            end
         end
         CMD_SCHEDULE: begin
            if (exists && in_item.finishes) begin
               if (mode_in == MODE_BAILOUT) begin
                  // critical job on its low budget in whole ms donates nothing
                  if (hi && in_cmp.gt) begin
                     drain = in_item.d_hs;
                  end else if (hi && !in_cmp.lt) begin
                     drain = '0;
                  end
                  fund_in = fund_sub(fund_in, drain);
                  if (fund_in <= 0) begin
                     mode_in = MODE_RECOVERY;
                  end
               end
               if (mode_in == MODE_RECOVERY && in_cmp.gt) begin
                  fund_in = in_item.d_hl;
                  mode_in = MODE_BAILOUT;
               end
               if (mode_in == MODE_RECOVERY && in_item.ident == low_task_ff) begin
                  low_task_in = '0;
                  mode_in     = MODE_NORMAL;
                  fund_in     = '0;
               end
            end
            if (mode_in == MODE_NORMAL && in_cmp.gt) begin
               fund_in = in_item.d_hl;
               mode_in = MODE_BAILOUT;
            end else if (mode_in == MODE_BAILOUT && in_cmp.gt) begin
               fund_in = fund_add(fund_in, in_item.d_hl);
            end
            if (in_item.idle && mode_in == MODE_BAILOUT) begin
               mode_in     = MODE_NORMAL;
               low_task_in = '0;
               fund_in     = '0;
            end
         end
         CMD_NEW_TASK: begin
            low_task_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NORMAL;
         fund_ff      <= '0;
         low_task_ff  <= '0;
         low_level_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            rsp_valid_ff <= in_valid;
         end
         if (fire) begin
            mode_ff      <= mode_in;
            fund_ff      <= fund_in;
            low_task_ff  <= low_task_in;
            low_level_ff <= low_level_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff.mode     <= mode_in;
         rsp_data_ff.fund     <= fund_in;
         rsp_data_ff.low_task <= low_task_in;
         rsp_data_ff.preempt  <= preempt_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_normal_no_fund: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_NORMAL |-> fund_ff == '0)
      else $error("fund held in normal mode");
   a_recovery_drained: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_RECOVERY |-> fund_ff <= 0)
      else $error("positive fund in recovery mode");
   a_preempt_only_end: assert property (@(posedge clock) disable iff (reset)
      fire && in_item.cmd != CMD_RELEASE_END |=> !rsp_data_ff.preempt)
      else $error("preempt raised outside release end");
`endif

endmodule

### src/bailout_mode_controller_unit.sv
`timescale 1ns / 1ps
// path: a word taken from req_chan passes the product, compare and result registers in turn to rsp_chan
// throughput: one word per cycle, back to back; a stalled rsp_chan holds every stage
// two pipeline registers form the millisecond quotients by reciprocal multiplication,
// the third is the result register behind the mode and fund update
// reset: synchronous, clears every stage valid, the result valid, the mode (normal),
// the fund and the tracked lowest-priority task

module bailout_mode_controller_unit import bmc_pkg::*; #(
   parameter int TIME_BITS = 48
) (
   input logic      clock,
   input logic      reset,
   bmc_req_if.sink  req_chan,
   bmc_rsp_if.source rsp_chan
);

   // wide enough for a time difference and for the fund limits
   localparam int WIDE_BITS  = (TIME_BITS + 1 > FUND_BITS) ? TIME_BITS + 1 : FUND_BITS;

   // signed a - b of two unsigned times, saturated to the fund range
   function automatic fund_type time_diff(input logic [TIME_BITS-1:0] a,
                                          input logic [TIME_BITS-1:0] b);
      logic signed [WIDE_BITS-1:0] d;
      d = $signed(WIDE_BITS'(a)) - $signed(WIDE_BITS'(b));
      if (d > WIDE_BITS'(FUND_MAX)) begin
         return FUND_MAX;
      end else if (d < WIDE_BITS'(FUND_MIN)) begin
         return FUND_MIN;
      end
      return d[FUND_BITS-1:0];
   endfunction

   cmd_type              cmd;
   logic                 zero_times;
   logic [TIME_BITS-1:0] st_time, lo_time, hi_time;
   item_type             prep_item;
   logic                 ms_valid, ms_ready;
   item_type             ms_item;
   cmp_type              ms_cmp;
   rsp_type              rsp_data;

   // entry: a missing running task counts as zero times on release begin and
   // schedule words; the time differences are formed here so the core only
   // adds them to the fund
   always_comb begin
      cmd        = cmd_type'(req_chan.command);
      zero_times = (cmd == CMD_RELEASE_BEGIN || cmd == CMD_SCHEDULE)
                   && req_chan.task_ident == '0;
      st_time    = zero_times ? '0 : req_chan.exec_time;
      lo_time    = zero_times ? '0 : req_chan.budget_low;
      hi_time    = zero_times ? '0 : req_chan.budget_high;

      prep_item.cmd       = cmd;
      prep_item.crit      = req_chan.is_critical;
      prep_item.ident     = req_chan.task_ident;
      prep_item.level     = req_chan.task_level;
      prep_item.finishes  = req_chan.job_finishes;
      prep_item.idle      = req_chan.goes_idle;
      prep_item.outranks  = req_chan.head_outranks;
      prep_item.head_crit = req_chan.head_critical;
      prep_item.st_gt_lo  = st_time > lo_time;
      prep_item.d_hl      = time_diff(hi_time, lo_time);
      prep_item.d_ls      = time_diff(lo_time, st_time);
      prep_item.d_hs      = time_diff(hi_time, st_time);
      prep_item.d_l0      = time_diff(lo_time, '0);
   end

   // millisecond compare: partial products in the first register, quotients
   // summed and compared into the second
   bmc_div_stage #(
      .TIME_BITS (TIME_BITS)
   ) u_ms (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_item   (prep_item),
      .in_st     (st_time),
      .in_lo     (lo_time),
      .out_valid (ms_valid),
      .out_ready (ms_ready),
      .out_item  (ms_item),
      .out_cmp   (ms_cmp)
   );

   // mode, fund and lowest-task update with the result register behind it
   bmc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ms_valid),
      .in_ready  (ms_ready),
      .in_item   (ms_item),
      .in_cmp    (ms_cmp),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_chan.mode_now      = rsp_data.mode;
   assign rsp_chan.fund_now      = rsp_data.fund;
   assign rsp_chan.low_prio_task = rsp_data.low_task;
   assign rsp_chan.preempt_now   = rsp_data.preempt;

endmodule
